// File: sv/triangular_matrix_multiply_top_macros.svh
// Assertion macros for the triangular matrix multiply block
`ifndef TRIANGULAR_MATRIX_MULTIPLY_TOP_MACROS_SVH
`define TRIANGULAR_MATRIX_MULTIPLY_TOP_MACROS_SVH

// check that a condition implies another on the same edge
`define TMM_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// check that a condition implies another on the next edge
`define TMM_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: sv/tmm_pkg.sv
package tmm_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW  = 4;
  localparam int unsigned DimW  = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam logic signed [DataW-1:0] QOne = 32'sd65536;

  typedef enum logic [1:0] {
    ACT_WRITE_A = 2'd0,
    ACT_WRITE_B = 2'd1,
    ACT_RUN     = 2'd2,
    ACT_READ_B  = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SIDE_RIGHT  = 3'd0,
    REG_UPPER       = 3'd1,
    REG_TRANSPOSE_A = 3'd2,
    REG_UNIT_DIAG   = 3'd3,
    REG_ALPHA       = 3'd4,
    REG_ORDER_N     = 3'd5,
    REG_OTHER_M     = 3'd6,
    REG_SPARE       = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MAC,
    ST_SCALE,
    ST_WRITE,
    ST_COPY,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       side_right;
    logic       upper;
    logic       transpose_a;
    logic       unit_diag;
    logic signed [DataW-1:0] alpha;
    logic [DimW-1:0] order_n;
    logic [DimW-1:0] other_m;
  } cfg_t;

  typedef struct packed {
    logic [1:0]             action;
    logic [IdxW-1:0]        row;
    logic [IdxW-1:0]        col;
    logic signed [DataW-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [DataW-1:0] read_value;
    logic                    is_completion;
    logic                    overflow;
  } out_word_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [DataW-1:0]   data;
  } cfg_word_t;

endpackage

// File: sv/tmm_stream_if.sv
interface tmm_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/tmm_mac.sv
module tmm_mac (
  input  logic                        clk_i,
  input  logic                        clr_i,
  input  logic                        acc_en_i,
  input  logic                        scale_en_i,
  input  logic signed [tmm_pkg::DataW-1:0] a_i,
  input  logic signed [tmm_pkg::DataW-1:0] b_i,
  output logic signed [tmm_pkg::DataW-1:0] res_o,
  output logic                        sat_o
);
  import tmm_pkg::*;

  localparam int unsigned AccW = 2 * DataW + 8;

  logic signed [AccW-1:0]    acc_q, acc_d;
  logic signed [2*DataW-1:0] prod;
  logic signed [DataW-1:0]   mul_a, mul_b;
  logic signed [DataW-1:0]   dot;
  logic                      dot_sat;
  logic signed [2*DataW-1:0] sh;

  always_comb begin
    dot_sat = 1'b0;
    dot = acc_q[DataW-1:0];
    if (acc_q > AccW'(32'sh7fffffff)) begin
      dot = 32'sh7fffffff;
      dot_sat = 1'b1;
    end else if (acc_q < -AccW'(64'sh80000000)) begin
      dot = 32'sh80000000;
      dot_sat = 1'b1;
    end
  end

  assign mul_a = scale_en_i ? dot : a_i;
  assign mul_b = scale_en_i ? a_i : b_i;
  assign prod  = mul_a * mul_b;
  assign sh    = prod >>> 16;

  always_comb begin
    acc_d = acc_q;
    if (clr_i) begin
      acc_d = '0;
    end else if (acc_en_i) begin
      acc_d = acc_q + AccW'(sh);
    end else if (scale_en_i) begin
      acc_d = AccW'(sh);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign res_o = dot;
  assign sat_o = dot_sat;
endmodule

// File: sv/tmm_ctrl.sv
module tmm_ctrl #(
  parameter int unsigned MAX_DIM = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  tmm_stream_if.sink   in_s,
  tmm_stream_if.source out_s,
  tmm_stream_if.sink   cfg_s
);
  import tmm_pkg::*;
  `include "triangular_matrix_multiply_top_macros.svh"

  localparam int unsigned DW    = $clog2(MAX_DIM + 1);
  localparam int unsigned KW    = $clog2(MAX_DIM);
  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = 2 * KW;

  cfg_t cfg_q;
  state_e state_q, state_d;
  logic ovf_q, ovf_d;
  logic [KW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [AW:0] cp_q, cp_d;
  logic [DW-1:0] n, m, rows, cols;
  logic first_q, first_d;
  logic out_valid_q, out_valid_d;
  out_word_t out_q, out_d;

  logic signed [DataW-1:0] a_mem [DEPTH];
  logic signed [DataW-1:0] b_mem [DEPTH];
  logic signed [DataW-1:0] t_mem [DEPTH];
  logic signed [DataW-1:0] a_rd_q, b_rd_q, t_rd_q;
  logic [KW-1:0] ar, ac, br, bc;
  logic [AW-1:0] a_addr, b_addr, w_addr, cp_addr;
  logic a_we, b_we, t_we, b_cp_we;
  logic [AW-1:0] in_addr;
  logic in_inside;
  logic use_a, diag, keep, unit_q, zero_q;
  logic signed [DataW-1:0] a_op;
  logic mac_clr, mac_acc, mac_scale;
  logic signed [DataW-1:0] mac_res;
  logic mac_sat;
  logic take;

  function automatic logic [DW-1:0] clamp(input logic [DimW-1:0] d);
    if (32'(d) > MAX_DIM) begin
      return DW'(MAX_DIM);
    end
    return DW'(d);
  endfunction

  assign n = clamp(cfg_q.order_n);
  assign m = clamp(cfg_q.other_m);
  assign rows = cfg_q.side_right ? m : n;
  assign cols = cfg_q.side_right ? n : m;
  assign in_inside = (32'(in_s.data.row) < MAX_DIM) && (32'(in_s.data.col) < MAX_DIM);
  assign in_addr = AW'(in_s.data.row) * AW'(MAX_DIM) + AW'(in_s.data.col);

  always_comb begin
    if (cfg_q.side_right) begin
      br = i_q; bc = k_q;
      if (cfg_q.transpose_a) begin ar = j_q; ac = k_q; end
      else begin ar = k_q; ac = j_q; end
    end else begin
      br = k_q; bc = j_q;
      if (cfg_q.transpose_a) begin ar = k_q; ac = i_q; end
      else begin ar = i_q; ac = k_q; end
    end
  end
  assign a_addr = AW'(ar) * AW'(MAX_DIM) + AW'(ac);
  assign b_addr = AW'(br) * AW'(MAX_DIM) + AW'(bc);
  assign w_addr = AW'(i_q) * AW'(MAX_DIM) + AW'(j_q);
  assign cp_addr = cp_q[AW-1:0];
  assign diag = (ar == ac);
  assign keep = cfg_q.upper ? (ac > ar) : (ac < ar);

  assign take = in_s.valid && in_s.ready;
  assign a_we = take && in_s.data.action == ACT_WRITE_A && in_inside;
  assign b_we = take && in_s.data.action == ACT_WRITE_B && in_inside;

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem[in_addr] <= in_s.data.value;
    end
    a_rd_q <= a_mem[a_addr];
    unit_q <= diag && cfg_q.unit_diag;
    zero_q <= !diag && !keep;
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      b_mem[in_addr] <= in_s.data.value;
    end else if (b_cp_we) begin
      b_mem[cp_addr] <= t_rd_q;
    end
    b_rd_q <= (state_q == ST_IDLE) ? b_mem[in_addr] : b_mem[b_addr];
  end

  always_ff @(posedge clk_i) begin
    if (t_we) begin
      t_mem[w_addr] <= mac_res;
    end
    t_rd_q <= t_mem[w_addr];
  end

  assign a_op = unit_q ? QOne : (zero_q ? '0 : a_rd_q);

  tmm_mac u_mac (
    .clk_i      (clk_i),
    .clr_i      (mac_clr),
    .acc_en_i   (mac_acc),
    .scale_en_i (mac_scale),
    .a_i        (mac_scale ? cfg_q.alpha : a_op),
    .b_i        (b_rd_q),
    .res_o      (mac_res),
    .sat_o      (mac_sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{side_right: 1'b0, upper: 1'b1, transpose_a: 1'b0, unit_diag: 1'b0,
                 alpha: QOne, order_n: DimW'(16), other_m: DimW'(16)};
    end else if (cfg_s.valid && cfg_s.ready) begin
      case (reg_e'(cfg_s.data.index))
        REG_SIDE_RIGHT:  cfg_q.side_right  <= cfg_s.data.data[0];
        REG_UPPER:       cfg_q.upper       <= cfg_s.data.data[0];
        REG_TRANSPOSE_A: cfg_q.transpose_a <= cfg_s.data.data[0];
        REG_UNIT_DIAG:   cfg_q.unit_diag   <= cfg_s.data.data[0];
        REG_ALPHA:       cfg_q.alpha       <= cfg_s.data.data;
        REG_ORDER_N:     cfg_q.order_n     <= cfg_s.data.data[DimW-1:0];
        REG_OTHER_M:     cfg_q.other_m     <= cfg_s.data.data[DimW-1:0];
        default: ;
      endcase
    end
  end
  assign cfg_s.ready = 1'b1;

  always_comb begin
    state_d = state_q;
    i_d = i_q; j_d = j_q; k_d = k_q; cp_d = cp_q;
    first_d = first_q;
    ovf_d = ovf_q;
    out_valid_d = out_valid_q;
    out_d = out_q;
    mac_clr = 1'b0; mac_acc = 1'b0; mac_scale = 1'b0;
    t_we = 1'b0; b_cp_we = 1'b0;
    in_s.ready = 1'b0;
    if (out_s.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        in_s.ready = !out_valid_q || out_s.ready;
        if (take) begin
          case (action_e'(in_s.data.action))
            ACT_READ_B: begin
              state_d = ST_DONE;
              first_d = in_inside;
            end
            ACT_RUN: begin
              i_d = '0; j_d = '0; k_d = '0;
              if (rows == '0 || cols == '0) begin
                out_valid_d = 1'b1;
                out_d = '{read_value: '0, is_completion: 1'b1, overflow: ovf_q};
              end else begin
                state_d = ST_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DONE: begin
        out_valid_d = 1'b1;
        out_d = '{read_value: first_q ? b_rd_q : '0, is_completion: 1'b0, overflow: ovf_q};
        state_d = ST_IDLE;
      end
      ST_FETCH: begin
        mac_clr = 1'b1;
        k_d = k_q + 1'b1;
        first_d = (32'(k_q) + 1 >= 32'(n));
        state_d = ST_MAC;
      end
      ST_MAC: begin
        mac_acc = 1'b1;
        if (first_q) begin
          state_d = ST_SCALE;
        end else begin
          k_d = k_q + 1'b1;
          first_d = (32'(k_q) + 1 >= 32'(n));
        end
      end
      ST_SCALE: begin
        mac_scale = 1'b1;
        if (mac_sat) begin
          ovf_d = 1'b1;
        end
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        t_we = 1'b1;
        if (mac_sat) begin
          ovf_d = 1'b1;
        end
        k_d = '0;
        state_d = ST_FETCH;
        if (32'(j_q) + 1 >= 32'(cols)) begin
          j_d = '0;
          if (32'(i_q) + 1 >= 32'(rows)) begin
            state_d = ST_COPY;
            i_d = '0;
            cp_d = '0;
            first_d = 1'b0;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_COPY: begin
        b_cp_we = first_q;
        if (!cp_q[AW]) begin
          cp_d = {1'b0, w_addr};
          first_d = 1'b1;
          if (32'(j_q) + 1 >= 32'(cols)) begin
            j_d = '0;
            if (32'(i_q) + 1 >= 32'(rows)) begin
              cp_d = {1'b1, w_addr};
            end else begin
              i_d = i_q + 1'b1;
            end
          end else begin
            j_d = j_q + 1'b1;
          end
        end else begin
          first_d = 1'b0;
          if (!out_valid_q || out_s.ready) begin
            state_d = ST_IDLE;
            out_valid_d = 1'b1;
            out_d = '{read_value: '0, is_completion: 1'b1, overflow: ovf_q};
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ovf_q <= 1'b0;
      out_valid_q <= 1'b0;
      i_q <= '0; j_q <= '0; k_q <= '0; cp_q <= '0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ovf_q <= ovf_d;
      out_valid_q <= out_valid_d;
      i_q <= i_d; j_q <= j_d; k_q <= k_d; cp_q <= cp_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_s.valid = out_valid_q;
  assign out_s.data  = out_q;

  `TMM_ASSERT_NEXT(a_ovf_sticky, clk_i, rst_ni, ovf_q, ovf_q, "overflow flag dropped")
  `TMM_ASSERT_IMP(a_busy_not_ready, clk_i, rst_ni, state_q != ST_IDLE, !in_s.ready,
                  "input taken while busy")
  `TMM_ASSERT_IMP(a_write_window, clk_i, rst_ni, t_we, 32'(i_q) < 32'(rows),
                  "result row outside window")
endmodule

// File: sv/triangular_matrix_multiply_top.sv
// Triangular matrix multiply. Write A (action 0) and B (action 1) entries at one
// word per cycle while idle and the output is not stalled; a read of B (action 3)
// registers its B word and then its output word. A run (action 2) works
// B := alpha*op(A)*B or alpha*B*op(A) on one shared multiplier with a wide
// accumulator: each result entry is summed over the order n, scaled by alpha and held
// until all are copied back into B. Input is not ready during a run.
module triangular_matrix_multiply_top #(
  parameter int unsigned MAX_DIM = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  tmm_stream_if.sink   in_s,
  tmm_stream_if.source out_s,
  tmm_stream_if.sink   cfg_s
);
  import tmm_pkg::*;

  tmm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_s   (in_s),
    .out_s  (out_s),
    .cfg_s  (cfg_s)
  );
endmodule

// File: tb/tb_triangular_matrix_multiply_top.sv
module tb_triangular_matrix_multiply_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tmm_pkg::*;

  localparam int unsigned Dim = 16;

  logic clk_i;
  logic rst_ni;

  tmm_stream_if #(.word_t(in_word_t))  in_if ();
  tmm_stream_if #(.word_t(out_word_t)) out_if ();
  tmm_stream_if #(.word_t(cfg_word_t)) cfg_if ();

  triangular_matrix_multiply_top #(.MAX_DIM(Dim)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_s  (in_if.sink),
    .out_s (out_if.source),
    .cfg_s (cfg_if.sink)
  );

  // model copy of the block's state and registers
  logic signed [DataW-1:0] a_mem [Dim*Dim];
  logic signed [DataW-1:0] b_mem [Dim*Dim];
  logic                    ovf_seen;
  logic                    m_side_right, m_upper, m_transpose, m_unit_diag;
  logic signed [DataW-1:0] m_alpha;
  logic [DimW-1:0]         m_order_n, m_other_m;

  out_word_t expected_q [$];
  int        errors;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        n_runs, n_reads, n_cfg;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk_i) begin
    out_word_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", got));
      end else begin
        want = expected_q.pop_front();
        if (got.read_value !== want.read_value)
          report_mismatch($sformatf("read_value %h, want %h", got.read_value,
                                    want.read_value));
        if (got.is_completion !== want.is_completion)
          report_mismatch($sformatf("is_completion %b, want %b", got.is_completion,
                                    want.is_completion));
        if (got.overflow !== want.overflow)
          report_mismatch($sformatf("overflow %b, want %b", got.overflow,
                                    want.overflow));
      end
    end
  end

  function automatic logic signed [DataW-1:0] clip_word(input longint v);
    if (v > 64'sd2147483647) begin
      ovf_seen = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      ovf_seen = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [DataW-1:0] tri_entry(input int r, input int c);
    if (r == c) return m_unit_diag ? QOne : a_mem[r*Dim+c];
    if (m_upper ? (c > r) : (c < r)) return a_mem[r*Dim+c];
    return '0;
  endfunction

  function automatic logic signed [DataW-1:0] op_entry(input int r, input int c);
    return m_transpose ? tri_entry(c, r) : tri_entry(r, c);
  endfunction

  function automatic void multiply_b();
    logic signed [DataW-1:0] b_new [Dim*Dim];
    logic signed [DataW-1:0] dot;
    int n, m, rows, cols;
    longint acc, p;
    n = (m_order_n > Dim) ? Dim : m_order_n;
    m = (m_other_m > Dim) ? Dim : m_other_m;
    rows = m_side_right ? m : n;
    cols = m_side_right ? n : m;
    b_new = b_mem;
    for (int i = 0; i < rows; i++) begin
      for (int j = 0; j < cols; j++) begin
        acc = 0;
        for (int k = 0; k < n; k++) begin
          if (m_side_right) p = longint'(b_mem[i*Dim+k]) * longint'(op_entry(k, j));
          else p = longint'(op_entry(i, k)) * longint'(b_mem[k*Dim+j]);
          acc += p >>> 16;
        end
        dot = clip_word(acc);
        b_new[i*Dim+j] = clip_word((longint'(dot) * longint'(m_alpha)) >>> 16);
      end
    end
    b_mem = b_new;
  endfunction

  function automatic void predict_word(input in_word_t w);
    out_word_t r;
    case (action_e'(w.action))
      ACT_WRITE_A: a_mem[w.row*Dim+w.col] = w.value;
      ACT_WRITE_B: b_mem[w.row*Dim+w.col] = w.value;
      ACT_RUN: begin
        multiply_b();
        r.read_value = '0;
        r.is_completion = 1'b1;
        r.overflow = ovf_seen;
        expected_q.push_back(r);
        n_runs++;
      end
      default: begin
        r.read_value = b_mem[w.row*Dim+w.col];
        r.is_completion = 1'b0;
        r.overflow = ovf_seen;
        expected_q.push_back(r);
        n_reads++;
      end
    endcase
  endfunction

  task automatic send_word(input action_e act, input int r, input int c,
                           input logic signed [DataW-1:0] v);
    in_word_t w;
    w.action = act;
    w.row = r[IdxW-1:0];
    w.col = c[IdxW-1:0];
    w.value = v;
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= w;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_word(w);
  endtask

  // hold input until every expected word is back and the block has settled
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [DataW-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= '{index: idx, data: d};
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      REG_SIDE_RIGHT:  m_side_right = d[0];
      REG_UPPER:       m_upper = d[0];
      REG_TRANSPOSE_A: m_transpose = d[0];
      REG_UNIT_DIAG:   m_unit_diag = d[0];
      REG_ALPHA:       m_alpha = d;
      REG_ORDER_N:     m_order_n = d[DimW-1:0];
      REG_OTHER_M:     m_other_m = d[DimW-1:0];
      default: ;
    endcase
    n_cfg++;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [DataW-1:0] pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
    if (sel < 90) return $urandom;
    case ($urandom_range(4))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return QOne;
      3: return -QOne;
      default: return '0;
    endcase
  endfunction

  function automatic int pick_dim();
    int sel;
    sel = $urandom_range(99);
    if (sel < 90) return $urandom_range(1, 4);
    if (sel < 96) return $urandom_range(5, 8);
    return Dim;
  endfunction

  // fill both stores so no run or read ever touches an unwritten entry
  task automatic test_fill();
    for (int r = 0; r < Dim; r++)
      for (int c = 0; c < Dim; c++) begin
        send_word(ACT_WRITE_A, r, c, pick_value());
        send_word(ACT_WRITE_B, r, c, pick_value());
      end
  endtask

  task automatic test_directed();
    send_word(ACT_READ_B, 0, 0, '0);
    send_word(ACT_READ_B, 15, 15, 32'sh7fffffff);
    send_word(ACT_WRITE_B, 15, 0, 32'sh80000000);
    send_word(ACT_READ_B, 15, 0, '0);
    send_word(ACT_RUN, 0, 0, '0);
    drain();
    write_reg(REG_ORDER_N, 0);
    write_reg(REG_OTHER_M, 3);
    send_word(ACT_RUN, 0, 0, '0);
    send_word(ACT_READ_B, 0, 0, '0);
    drain();
    write_reg(REG_ORDER_N, 31);
    write_reg(REG_OTHER_M, 1);
    write_reg(REG_SIDE_RIGHT, 1);
    write_reg(REG_UPPER, 0);
    write_reg(REG_TRANSPOSE_A, 1);
    write_reg(REG_UNIT_DIAG, 1);
    write_reg(REG_ALPHA, 32'h7fffffff);
    send_word(ACT_RUN, 0, 0, '0);
    send_word(ACT_READ_B, 0, 15, '0);
    drain();
    write_reg(REG_ALPHA, 32'h80000000);
    write_reg(REG_ORDER_N, 2);
    write_reg(REG_OTHER_M, 0);
    send_word(ACT_RUN, 0, 0, '0);
    drain();
    write_reg(REG_OTHER_M, 2);
    write_reg(REG_SIDE_RIGHT, 0);
    write_reg(REG_ALPHA, 32'hffff0000);
    send_word(ACT_WRITE_A, 0, 1, QOne);
    send_word(ACT_RUN, 0, 0, '0);
    send_word(ACT_READ_B, 1, 1, '0);
    send_word(ACT_READ_B, 0, 1, '0);
    drain();
  endtask

  task automatic random_config();
    write_reg(REG_SIDE_RIGHT, $urandom_range(1));
    write_reg(REG_UPPER, $urandom_range(1));
    write_reg(REG_TRANSPOSE_A, $urandom_range(1));
    write_reg(REG_UNIT_DIAG, $urandom_range(1));
    write_reg(REG_ALPHA, ($urandom_range(9) == 0) ? $urandom :
              $signed($urandom_range(0, 4 << 16)) - (2 << 16));
    write_reg(REG_ORDER_N, ($urandom_range(29) == 0) ? $urandom_range(17, 31) : pick_dim());
    write_reg(REG_OTHER_M, ($urandom_range(29) == 0) ? 0 : pick_dim());
  endtask

  task automatic test_random(input int count, input int idle, input int stall);
    int sel;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        drain();
        random_config();
      end
      sel = $urandom_range(99);
      if (sel < 40) send_word(ACT_WRITE_A, $urandom_range(15), $urandom_range(15), pick_value());
      else if (sel < 80)
        send_word(ACT_WRITE_B, $urandom_range(15), $urandom_range(15), pick_value());
      else if (sel < 88) send_word(ACT_RUN, $urandom_range(15), $urandom_range(15), $urandom);
      else send_word(ACT_READ_B, $urandom_range(15), $urandom_range(15), $urandom);
    end
  endtask

  initial begin
    errors = 0;
    n_runs = 0;
    n_reads = 0;
    n_cfg = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    ovf_seen = 1'b0;
    m_side_right = 1'b0;
    m_upper = 1'b1;
    m_transpose = 1'b0;
    m_unit_diag = 1'b0;
    m_alpha = QOne;
    m_order_n = 16;
    m_other_m = 16;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill();
    test_directed();
    test_random(460, 18, 52);
    test_random(460, 52, 18);
    test_random(460, 0, 0);
    drain();
    repeat (50) @(posedge clk_i);
    $display("Covered %0d runs, %0d B reads and %0d register writes", n_runs, n_reads, n_cfg);
    $display("across left/right, upper/lower, transpose and unit-diagonal settings.");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
